// ===== design/ibm_pkg.sv =====
// ----------------------------------------------------------------------------
// ibm_pkg
// Shared types and codes for the inode block map unit.
// ----------------------------------------------------------------------------
package ibm_pkg;

   localparam int LIDX_W   = 13;   // logical index width
   localparam int COUNT_W  = 13;   // reported entry count width
   localparam int SPARES_W = 2;

   localparam logic [SPARES_W-1:0] SPARES_NONE = 2'd0;
   localparam logic [SPARES_W-1:0] SPARES_ONE  = 2'd1;
   localparam logic [SPARES_W-1:0] SPARES_TWO  = 2'd2;
   localparam logic [SPARES_W-1:0] SPARES_ALL  = 2'd3;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_APPEND = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REGION_DIRECT = 2'd0,
      REGION_SINGLE = 2'd1,
      REGION_DOUBLE = 2'd2
   } region_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_RANGE  = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_SPARES = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_APP_ISSUE = 3'd1,
      ST_APP_WAIT  = 3'd2,
      ST_LOOK_PTR  = 3'd3,
      ST_LOOK_DATA = 3'd4
   } state_type;

   // Classified request control, front to back
   typedef struct packed {
      op_type                op;
      region_type            region;
      logic [SPARES_W-1:0]   offered;   // saturated to two
      logic [LIDX_W-1:0]     lidx;
   } ctl_type;

endpackage

// ===== design/ibm_ram.sv =====
// ----------------------------------------------------------------------------
// ibm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ibm_ram #(
   parameter int              WIDTH = 8,
   parameter longint unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ibm_queue.sv =====
// ----------------------------------------------------------------------------
// ibm_queue
// Small FIFO between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module ibm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   input  logic             out_pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign push      = in_valid && in_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (out_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !out_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && out_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== design/ibm_front.sv =====
// ----------------------------------------------------------------------------
// ibm_front
// Accepts requests, classifies the lookup region and splits a
// double-indirect index into index-block slot and offset.
// ----------------------------------------------------------------------------
module ibm_front #(
   parameter int DIRECT_SLOTS  = 12,
   parameter int IDS_PER_BLOCK = 64,
   parameter int BLOCK_ID_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_operation,
   input  logic [ibm_pkg::LIDX_W-1:0]       req_logical_index,
   input  logic [BLOCK_ID_BITS-1:0]         req_new_block,
   input  logic [BLOCK_ID_BITS-1:0]         req_spare_first,
   input  logic [BLOCK_ID_BITS-1:0]         req_spare_second,
   input  logic [ibm_pkg::SPARES_W-1:0]     req_spares_offered,
   output logic                             out_valid,
   input  logic                             out_ready,
   output ibm_pkg::ctl_type                 out_ctl,
   output logic [BLOCK_ID_BITS-1:0]         out_new_block,
   output logic [BLOCK_ID_BITS-1:0]         out_spare_first,
   output logic [BLOCK_ID_BITS-1:0]         out_spare_second,
   output logic [$clog2(IDS_PER_BLOCK)-1:0] out_outer,
   output logic [$clog2(IDS_PER_BLOCK)-1:0] out_inner
);

   localparam int N     = ibm_pkg::LIDX_W;
   localparam int OW    = $clog2(IDS_PER_BLOCK);
   localparam int SHIFT = N + OW;
   localparam int RW    = N + 1;
   localparam int PW    = N + RW;
   // floor reciprocal: estimate is exact or one short for any N-bit dividend
   localparam int RECIP = (1 << SHIFT) / IDS_PER_BLOCK;

   logic                     a_valid_ff, a_valid_in;
   ibm_pkg::ctl_type         a_ctl_ff, a_ctl_in;
   logic [BLOCK_ID_BITS-1:0] a_new_ff, a_s1_ff, a_s2_ff;
   logic [N-1:0]             a_n_ff, a_n_in;
   logic [N-1:0]             a_qest_ff, a_qest_in;
   logic                     a_load;

   logic [31:0]              lidx32;
   logic [N-1:0]             n_single, n_double;
   logic [PW-1:0]            recip_prod;
   logic [N-1:0]             qp, rem, q_fix, r_fix;
   logic                     fix;

   assign req_ready = !a_valid_ff || out_ready;
   assign a_load    = req_valid && req_ready;

   assign lidx32   = 32'(req_logical_index);
   assign n_single = req_logical_index - N'(DIRECT_SLOTS);
   assign n_double = req_logical_index - N'(DIRECT_SLOTS + IDS_PER_BLOCK);
   assign recip_prod = PW'(n_double) * PW'(RECIP);

   always_comb begin
      a_ctl_in.op      = ibm_pkg::op_type'(req_operation);
      a_ctl_in.offered = (req_spares_offered == ibm_pkg::SPARES_ALL) ?
                         ibm_pkg::SPARES_TWO : req_spares_offered;
      a_ctl_in.lidx    = req_logical_index;
      if (lidx32 < 32'(DIRECT_SLOTS)) begin
         a_ctl_in.region = ibm_pkg::REGION_DIRECT;
      end else if (lidx32 < 32'(DIRECT_SLOTS + IDS_PER_BLOCK)) begin
         a_ctl_in.region = ibm_pkg::REGION_SINGLE;
      end else begin
         a_ctl_in.region = ibm_pkg::REGION_DOUBLE;
      end
      a_n_in    = (a_ctl_in.region == ibm_pkg::REGION_SINGLE) ? n_single : n_double;
      a_qest_in = N'(recip_prod >> SHIFT);
      a_valid_in = a_load ? 1'b1 : (out_ready ? 1'b0 : a_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_ctl_ff  <= a_ctl_in;
         a_new_ff  <= req_new_block;
         a_s1_ff   <= req_spare_first;
         a_s2_ff   <= req_spare_second;
         a_n_ff    <= a_n_in;
         a_qest_ff <= a_qest_in;
      end
   end

   // remainder and one-step correction of the quotient estimate
   assign qp    = a_qest_ff * N'(IDS_PER_BLOCK);
   assign rem   = a_n_ff - qp;
   assign fix   = rem >= N'(IDS_PER_BLOCK);
   assign q_fix = fix ? a_qest_ff + N'(1) : a_qest_ff;
   assign r_fix = fix ? rem - N'(IDS_PER_BLOCK) : rem;

   assign out_valid        = a_valid_ff;
   assign out_ctl          = a_ctl_ff;
   assign out_new_block    = a_new_ff;
   assign out_spare_first  = a_s1_ff;
   assign out_spare_second = a_s2_ff;
   assign out_outer        = OW'(q_fix);
   assign out_inner        = (a_ctl_ff.region == ibm_pkg::REGION_SINGLE) ?
                             OW'(a_n_ff) : OW'(r_fix);

endmodule

// ===== design/ibm_back.sv =====
// ----------------------------------------------------------------------------
// ibm_back
// Executes classified requests against the direct slots, the roots and
// the index store, and holds the result register.
// ----------------------------------------------------------------------------
module ibm_back #(
   parameter int DIRECT_SLOTS  = 12,
   parameter int IDS_PER_BLOCK = 64,
   parameter int MAX_ENTRIES   = 4172,
   parameter int BLOCK_ID_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             hd_valid,
   input  ibm_pkg::ctl_type                 hd_ctl,
   input  logic [BLOCK_ID_BITS-1:0]         hd_new_block,
   input  logic [BLOCK_ID_BITS-1:0]         hd_spare_first,
   input  logic [BLOCK_ID_BITS-1:0]         hd_spare_second,
   input  logic [$clog2(IDS_PER_BLOCK)-1:0] hd_outer,
   input  logic [$clog2(IDS_PER_BLOCK)-1:0] hd_inner,
   output logic                             hd_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [BLOCK_ID_BITS-1:0]         rsp_found_block,
   output logic [ibm_pkg::SPARES_W-1:0]     rsp_spares_used,
   output logic [ibm_pkg::COUNT_W-1:0]      rsp_entry_count
);

   localparam int              B    = BLOCK_ID_BITS;
   localparam int              CW   = $clog2(MAX_ENTRIES + 1);
   localparam int              OW   = $clog2(IDS_PER_BLOCK);
   localparam int              OUTW = $clog2(IDS_PER_BLOCK + 1);
   localparam int              DIW  = (DIRECT_SLOTS > 1) ? $clog2(DIRECT_SLOTS) : 1;
   localparam longint unsigned STORE_DEPTH = (64'd1 << B) * 64'(IDS_PER_BLOCK);
   localparam int              SAW  = $clog2(STORE_DEPTH);
   localparam int              CNT_OUT_W = ibm_pkg::COUNT_W;

   ibm_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [OUTW-1:0]      tail_outer_ff, tail_outer_in;
   logic [OW-1:0]        tail_inner_ff, tail_inner_in;
   logic [B-1:0]         single_root_ff, single_root_in;
   logic [B-1:0]         double_root_ff, double_root_in;
   logic [B-1:0]         direct_ff [DIRECT_SLOTS];
   logic                 direct_we;
   logic [DIW-1:0]       direct_idx;

   logic                     rsp_valid_ff, rsp_valid_in;
   ibm_pkg::status_type      rsp_status_ff, rsp_status_in;
   logic [B-1:0]             rsp_found_ff, rsp_found_in;
   logic [ibm_pkg::SPARES_W-1:0] rsp_used_ff, rsp_used_in;
   logic [CNT_OUT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                     rsp_load, rsp_free;

   logic                 ram_we, ram_re;
   logic [SAW-1:0]       ram_waddr, ram_raddr;
   logic [B-1:0]         ram_wdata, ram_rdata;

   logic [31:0]          cnt32, lidx32;
   logic                 a_full, a_direct, a_single, s_need;
   logic                 d_full, d_need2, d_need1;
   logic [ibm_pkg::SPARES_W-1:0] need;
   logic                 fail_full, fail_spares, app_dbl, l_miss;
   logic [CW-1:0]        cnt_inc;

   function automatic logic [SAW-1:0] store_addr(input logic [B-1:0]   id,
                                                 input logic [SAW-1:0] off);
      return SAW'(id) * SAW'(IDS_PER_BLOCK) + off;
   endfunction

   assign cnt32    = 32'(cnt_ff);
   assign lidx32   = 32'(hd_ctl.lidx);
   assign cnt_inc  = cnt_ff + CW'(1);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // append classification from the current tail
   assign a_full   = cnt32 >= 32'(MAX_ENTRIES);
   assign a_direct = cnt32 < 32'(DIRECT_SLOTS);
   assign a_single = cnt32 < 32'(DIRECT_SLOTS + IDS_PER_BLOCK);
   assign s_need   = cnt32 == 32'(DIRECT_SLOTS);
   assign d_full   = tail_outer_ff == OUTW'(IDS_PER_BLOCK);
   assign d_need2  = (tail_outer_ff == '0) && (tail_inner_ff == '0);
   assign d_need1  = !d_need2 && (tail_inner_ff == '0);
   assign need     = a_single ? (s_need ? ibm_pkg::SPARES_ONE : ibm_pkg::SPARES_NONE) :
                     d_need2  ? ibm_pkg::SPARES_TWO :
                     d_need1  ? ibm_pkg::SPARES_ONE : ibm_pkg::SPARES_NONE;
   assign fail_full   = a_full || (!a_direct && !a_single && d_full);
   assign fail_spares = !fail_full && !a_direct && (hd_ctl.offered < need);
   assign app_dbl     = !fail_full && !fail_spares && !a_direct && !a_single;
   assign l_miss      = lidx32 >= cnt32;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ibm_pkg::ST_IDLE: begin
            if (hd_valid) begin
               if (hd_ctl.op == ibm_pkg::OP_LOOKUP) begin
                  if (!l_miss && hd_ctl.region == ibm_pkg::REGION_SINGLE) begin
                     state_in = ibm_pkg::ST_LOOK_DATA;
                  end else if (!l_miss && hd_ctl.region == ibm_pkg::REGION_DOUBLE) begin
                     state_in = ibm_pkg::ST_LOOK_PTR;
                  end
               end else if (app_dbl) begin
                  state_in = (d_need2 || d_need1) ? ibm_pkg::ST_APP_ISSUE :
                                                    ibm_pkg::ST_APP_WAIT;
               end
            end
         end
         ibm_pkg::ST_APP_ISSUE: state_in = ibm_pkg::ST_APP_WAIT;
         ibm_pkg::ST_APP_WAIT: begin
            if (rsp_free) begin
               state_in = ibm_pkg::ST_IDLE;
            end
         end
         ibm_pkg::ST_LOOK_PTR: state_in = ibm_pkg::ST_LOOK_DATA;
         ibm_pkg::ST_LOOK_DATA: begin
            if (rsp_free) begin
               state_in = ibm_pkg::ST_IDLE;
            end
         end
         default: state_in = ibm_pkg::ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      cnt_in         = cnt_ff;
      tail_outer_in  = tail_outer_ff;
      tail_inner_in  = tail_inner_ff;
      single_root_in = single_root_ff;
      double_root_in = double_root_ff;
      direct_we      = 1'b0;
      direct_idx     = DIW'(cnt_ff);
      ram_we         = 1'b0;
      ram_waddr      = '0;
      ram_wdata      = hd_new_block;
      ram_re         = 1'b0;
      ram_raddr      = '0;
      hd_pop         = 1'b0;
      rsp_load       = 1'b0;
      rsp_status_in  = ibm_pkg::STATUS_OK;
      rsp_found_in   = '0;
      rsp_used_in    = ibm_pkg::SPARES_NONE;

      case (state_ff)
         ibm_pkg::ST_IDLE: begin
            if (hd_valid) begin
               if (hd_ctl.op == ibm_pkg::OP_LOOKUP) begin
                  if (l_miss) begin
                     rsp_load      = rsp_free;
                     rsp_status_in = ibm_pkg::STATUS_RANGE;
                  end else begin
                     case (hd_ctl.region)
                        ibm_pkg::REGION_DIRECT: begin
                           rsp_load     = rsp_free;
                           rsp_found_in = direct_ff[hd_ctl.lidx[DIW-1:0]];
                        end
                        ibm_pkg::REGION_SINGLE: begin
                           ram_re    = 1'b1;
                           ram_raddr = store_addr(single_root_ff, SAW'(hd_inner));
                        end
                        ibm_pkg::REGION_DOUBLE: begin
                           ram_re    = 1'b1;
                           ram_raddr = store_addr(double_root_ff, SAW'(hd_outer));
                        end
                        default: ;
                     endcase
                  end
               end else if (fail_full) begin
                  rsp_load      = rsp_free;
                  rsp_status_in = ibm_pkg::STATUS_FULL;
               end else if (fail_spares) begin
                  rsp_load      = rsp_free;
                  rsp_status_in = ibm_pkg::STATUS_SPARES;
               end else if (a_direct) begin
                  rsp_load  = rsp_free;
                  direct_we = rsp_free;
                  if (rsp_free) begin
                     cnt_in = cnt_inc;
                  end
               end else if (a_single) begin
                  rsp_load    = rsp_free;
                  rsp_used_in = need;
                  if (rsp_free) begin
                     if (s_need) begin
                        single_root_in = hd_spare_first;
                     end
                     ram_we    = 1'b1;
                     ram_waddr = store_addr(s_need ? hd_spare_first : single_root_ff,
                                            SAW'(cnt32 - 32'(DIRECT_SLOTS)));
                     cnt_in    = cnt_inc;
                  end
               end else if (d_need2) begin
                  // open the double root: its first slot names the first leaf
                  double_root_in = hd_spare_first;
                  ram_we         = 1'b1;
                  ram_waddr      = store_addr(hd_spare_first, '0);
                  ram_wdata      = hd_spare_second;
               end else if (d_need1) begin
                  ram_we    = 1'b1;
                  ram_waddr = store_addr(double_root_ff, SAW'(tail_outer_ff));
                  ram_wdata = hd_spare_first;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = store_addr(double_root_ff, SAW'(tail_outer_ff));
               end
            end
         end
         ibm_pkg::ST_APP_ISSUE: begin
            ram_re    = 1'b1;
            ram_raddr = store_addr(double_root_ff, SAW'(tail_outer_ff));
         end
         ibm_pkg::ST_APP_WAIT: begin
            rsp_load    = rsp_free;
            rsp_used_in = need;
            if (rsp_free) begin
               ram_we    = 1'b1;
               ram_waddr = store_addr(ram_rdata, SAW'(tail_inner_ff));
               cnt_in    = cnt_inc;
               if (tail_inner_ff == OW'(IDS_PER_BLOCK - 1)) begin
                  tail_inner_in = '0;
                  tail_outer_in = tail_outer_ff + OUTW'(1);
               end else begin
                  tail_inner_in = tail_inner_ff + OW'(1);
               end
            end
         end
         ibm_pkg::ST_LOOK_PTR: begin
            ram_re    = 1'b1;
            ram_raddr = store_addr(ram_rdata, SAW'(hd_inner));
         end
         ibm_pkg::ST_LOOK_DATA: begin
            rsp_load     = rsp_free;
            rsp_found_in = ram_rdata;
         end
         default: ;
      endcase

      hd_pop       = rsp_load;
      rsp_count_in = CNT_OUT_W'(cnt_in);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ibm_pkg::ST_IDLE;
         cnt_ff        <= '0;
         tail_outer_ff <= '0;
         tail_inner_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         tail_outer_ff <= tail_outer_in;
         tail_inner_ff <= tail_inner_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      single_root_ff <= single_root_in;
      double_root_ff <= double_root_in;
      if (direct_we) begin
         direct_ff[direct_idx] <= hd_new_block;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_used_ff   <= rsp_used_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   ibm_ram #(
      .WIDTH (B),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_block = rsp_found_ff;
   assign rsp_spares_used = rsp_used_ff;
   assign rsp_entry_count = rsp_count_ff;

   // double-region tail counters track the list count
   a_tail_track: assert property (@(posedge clock) disable iff (reset)
      (cnt32 >= 32'(DIRECT_SLOTS + IDS_PER_BLOCK)) |->
      (cnt32 == 32'(DIRECT_SLOTS + IDS_PER_BLOCK) +
                32'(tail_outer_ff) * 32'(IDS_PER_BLOCK) + 32'(tail_inner_ff)))
      else $error("double-indirect tail out of step with list count");

   a_tail_idle: assert property (@(posedge clock) disable iff (reset)
      (cnt32 < 32'(DIRECT_SLOTS + IDS_PER_BLOCK)) |->
      (tail_outer_ff == '0 && tail_inner_ff == '0))
      else $error("double-indirect tail moved before region reached");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      cnt32 <= 32'(MAX_ENTRIES))
      else $error("list count past capacity");

   a_fail_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_status_in != ibm_pkg::STATUS_OK) |=> $stable(cnt_ff))
      else $error("failed request changed list count");

   a_store_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("index store read and written in one cycle");

endmodule

// ===== design/inode_block_map_unit.sv =====
// ----------------------------------------------------------------------------
// inode_block_map_unit
// Inode-style block map: direct slots, one single-indirect and one
// double-indirect index block held in an internal id store.
// ----------------------------------------------------------------------------
// Lookups that miss or hit a direct slot, refused appends and direct/single
//   appends are answered from the back's idle state; single-indirect lookups
//   and plain double appends wait on one store read; double-indirect lookups
//   and double appends that open an index block wait on two dependent store
//   accesses. The back sequencer serves one request at a time through the index
//   store's single read port; the front and queue hold later requests meanwhile.
// Reset: list empty, pipes and queue empty; store and slots need no clearing.
module inode_block_map_unit #(
   parameter int DIRECT_SLOTS  = 12,
   parameter int IDS_PER_BLOCK = 64,
   parameter int MAX_ENTRIES   = 4172,
   parameter int BLOCK_ID_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [ibm_pkg::LIDX_W-1:0]   req_logical_index,
   input  logic [BLOCK_ID_BITS-1:0]     req_new_block,
   input  logic [BLOCK_ID_BITS-1:0]     req_spare_first,
   input  logic [BLOCK_ID_BITS-1:0]     req_spare_second,
   input  logic [ibm_pkg::SPARES_W-1:0] req_spares_offered,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [BLOCK_ID_BITS-1:0]     rsp_found_block,
   output logic [ibm_pkg::SPARES_W-1:0] rsp_spares_used,
   output logic [ibm_pkg::COUNT_W-1:0]  rsp_entry_count
);

   localparam int B           = BLOCK_ID_BITS;
   localparam int OW          = $clog2(IDS_PER_BLOCK);
   localparam int CTL_W       = $bits(ibm_pkg::ctl_type);
   localparam int Q_W         = CTL_W + 3 * B + 2 * OW;
   localparam int QUEUE_DEPTH = 2;

   logic             f_valid, f_ready;
   ibm_pkg::ctl_type f_ctl, hd_ctl;
   logic [B-1:0]     f_new, f_s1, f_s2;
   logic [B-1:0]     hd_new, hd_s1, hd_s2;
   logic [OW-1:0]    f_outer, f_inner, hd_outer, hd_inner;
   logic [Q_W-1:0]   q_in_data, q_out_data;
   logic             hd_valid, hd_pop;

   ibm_front #(
      .DIRECT_SLOTS  (DIRECT_SLOTS),
      .IDS_PER_BLOCK (IDS_PER_BLOCK),
      .BLOCK_ID_BITS (BLOCK_ID_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_logical_index  (req_logical_index),
      .req_new_block      (req_new_block),
      .req_spare_first    (req_spare_first),
      .req_spare_second   (req_spare_second),
      .req_spares_offered (req_spares_offered),
      .out_valid          (f_valid),
      .out_ready          (f_ready),
      .out_ctl            (f_ctl),
      .out_new_block      (f_new),
      .out_spare_first    (f_s1),
      .out_spare_second   (f_s2),
      .out_outer          (f_outer),
      .out_inner          (f_inner)
   );

   assign q_in_data = {f_ctl, f_new, f_s1, f_s2, f_outer, f_inner};

   ibm_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (q_in_data),
      .out_valid (hd_valid),
      .out_data  (q_out_data),
      .out_pop   (hd_pop)
   );

   assign {hd_ctl, hd_new, hd_s1, hd_s2, hd_outer, hd_inner} = q_out_data;

   ibm_back #(
      .DIRECT_SLOTS  (DIRECT_SLOTS),
      .IDS_PER_BLOCK (IDS_PER_BLOCK),
      .MAX_ENTRIES   (MAX_ENTRIES),
      .BLOCK_ID_BITS (BLOCK_ID_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .hd_valid        (hd_valid),
      .hd_ctl          (hd_ctl),
      .hd_new_block    (hd_new),
      .hd_spare_first  (hd_s1),
      .hd_spare_second (hd_s2),
      .hd_outer        (hd_outer),
      .hd_inner        (hd_inner),
      .hd_pop          (hd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_block (rsp_found_block),
      .rsp_spares_used (rsp_spares_used),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ===== verif/inode_block_map_unit_test.sv =====
// ----------------------------------------------------------------------------
// inode_block_map_unit_test
// Self-checking bench for the inode block map unit. A short directed table
// comes first, then random lookups and appends that grow the map deep into
// the double-indirect region. Every response is checked in order against a
// predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module inode_block_map_unit_test;

   localparam int DIRECT_SLOTS  = 12;
   localparam int IDS_PER_BLOCK = 64;
   localparam int MAX_ENTRIES   = 4172;
   localparam int ID_BITS       = 10;
   localparam int SINGLE_END    = DIRECT_SLOTS + IDS_PER_BLOCK;
   localparam int STORE_DEPTH   = (1 << ID_BITS) * IDS_PER_BLOCK;
   localparam int DIR_W         = $clog2(DIRECT_SLOTS);
   localparam int SA_W          = $clog2(STORE_DEPTH);
   localparam int IDLE_PCT      = 23;
   localparam int MIX_ITEMS     = 1000;
   localparam int FILL_ITEMS    = 80;
   localparam int TAIL_ITEMS    = 150;
   localparam int HOLD_CYCLES   = 200;
   localparam int QUIET_LIMIT   = 2000;

   typedef enum {PHASE_MIX, PHASE_FILL, PHASE_TAIL} phase_type;

   typedef struct {
      ibm_pkg::op_type                op;
      logic [ibm_pkg::LIDX_W-1:0]     lidx;
      logic [ID_BITS-1:0]             new_block;
      logic [ID_BITS-1:0]             spare_first;
      logic [ID_BITS-1:0]             spare_second;
      logic [ibm_pkg::SPARES_W-1:0]   offered;
   } map_req_type;

   typedef struct {
      ibm_pkg::status_type            status;
      logic [ID_BITS-1:0]             found;
      logic [ibm_pkg::SPARES_W-1:0]   used;
      logic [ibm_pkg::COUNT_W-1:0]    count;
   } map_rsp_type;

   typedef struct {
      map_req_type req;
      bit          typed;
      map_rsp_type rsp;
   } map_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_operation = 1'b0;
   logic [ibm_pkg::LIDX_W-1:0]    req_logical_index = '0;
   logic [ID_BITS-1:0]            req_new_block = '0;
   logic [ID_BITS-1:0]            req_spare_first = '0;
   logic [ID_BITS-1:0]            req_spare_second = '0;
   logic [ibm_pkg::SPARES_W-1:0]  req_spares_offered = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_status;
   logic [ID_BITS-1:0]            rsp_found_block;
   logic [ibm_pkg::SPARES_W-1:0]  rsp_spares_used;
   logic [ibm_pkg::COUNT_W-1:0]   rsp_entry_count;

   // model of the map
   logic [ID_BITS-1:0]    direct_ids [DIRECT_SLOTS];
   logic [ID_BITS-1:0]    id_store [STORE_DEPTH];
   logic [ID_BITS-1:0]    single_root;
   logic [ID_BITS-1:0]    double_root;
   bit                    id_taken [1 << ID_BITS];
   int unsigned           list_len = 0;

   map_rsp_type           pending_outcomes [$];
   map_row_type           directed_rows [$];
   map_rsp_type           head;
   int unsigned           mismatches = 0;
   int unsigned           quiet_cycles = 0;
   int unsigned           hold_left = 0;
   bit                    hold_request = 1'b0;
   bit                    hold_served = 1'b0;
   bit                    calm = 1'b0;

   inode_block_map_unit #(
      .DIRECT_SLOTS  (DIRECT_SLOTS),
      .IDS_PER_BLOCK (IDS_PER_BLOCK),
      .MAX_ENTRIES   (MAX_ENTRIES),
      .BLOCK_ID_BITS (ID_BITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_logical_index  (req_logical_index),
      .req_new_block      (req_new_block),
      .req_spare_first    (req_spare_first),
      .req_spare_second   (req_spare_second),
      .req_spares_offered (req_spares_offered),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_block    (rsp_found_block),
      .rsp_spares_used    (rsp_spares_used),
      .rsp_entry_count    (rsp_entry_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [SA_W-1:0] slot_addr(logic [ID_BITS-1:0] blk, int unsigned off);
      return SA_W'((int'(blk) * IDS_PER_BLOCK + off) % STORE_DEPTH);
   endfunction

   // index blocks the next append has to open
   function automatic int unsigned spares_needed();
      int unsigned pos;
      if (list_len < DIRECT_SLOTS) return 0;
      if (list_len < SINGLE_END) return (list_len == DIRECT_SLOTS) ? 1 : 0;
      pos = list_len - SINGLE_END;
      if (pos == 0) return 2;
      return (pos % IDS_PER_BLOCK == 0) ? 1 : 0;
   endfunction

   function automatic map_rsp_type map_outcome(map_req_type q);
      map_rsp_type o;
      int unsigned pos;
      int unsigned want;
      int unsigned avail;
      logic [ID_BITS-1:0] leaf;
      o.status = ibm_pkg::STATUS_OK;
      o.found  = '0;
      o.used   = ibm_pkg::SPARES_NONE;
      if (q.op == ibm_pkg::OP_LOOKUP) begin
         if (q.lidx >= list_len) begin
            o.status = ibm_pkg::STATUS_RANGE;
         end else if (q.lidx < DIRECT_SLOTS) begin
            o.found = direct_ids[DIR_W'(q.lidx)];
         end else if (q.lidx < SINGLE_END) begin
            o.found = id_store[slot_addr(single_root, q.lidx - DIRECT_SLOTS)];
         end else begin
            pos   = q.lidx - SINGLE_END;
            leaf  = id_store[slot_addr(double_root, pos / IDS_PER_BLOCK)];
            o.found = id_store[slot_addr(leaf, pos % IDS_PER_BLOCK)];
         end
      end else begin
         want  = spares_needed();
         avail = (q.offered == ibm_pkg::SPARES_ALL) ? 2 : int'(q.offered);
         if (list_len >= MAX_ENTRIES ||
             list_len >= SINGLE_END + IDS_PER_BLOCK * IDS_PER_BLOCK) begin
            o.status = ibm_pkg::STATUS_FULL;
         end else if (avail < want) begin
            // failed append leaves the count alone
            o.status = ibm_pkg::STATUS_SPARES;
         end else begin
            if (list_len < DIRECT_SLOTS) begin
               direct_ids[DIR_W'(list_len)] = q.new_block;
            end else if (list_len < SINGLE_END) begin
               pos = list_len - DIRECT_SLOTS;
               if (want != 0) begin
                  single_root = q.spare_first;
                  id_taken[q.spare_first] = 1'b1;
               end
               id_store[slot_addr(single_root, pos)] = q.new_block;
            end else begin
               pos = list_len - SINGLE_END;
               if (want == 2) begin
                  double_root = q.spare_first;
                  id_store[slot_addr(double_root, 0)] = q.spare_second;
                  id_taken[q.spare_first]  = 1'b1;
                  id_taken[q.spare_second] = 1'b1;
               end else if (want == 1) begin
                  id_store[slot_addr(double_root, pos / IDS_PER_BLOCK)] = q.spare_first;
                  id_taken[q.spare_first] = 1'b1;
               end
               leaf = id_store[slot_addr(double_root, pos / IDS_PER_BLOCK)];
               id_store[slot_addr(leaf, pos % IDS_PER_BLOCK)] = q.new_block;
            end
            list_len++;
            o.used = ibm_pkg::SPARES_W'(want);
         end
      end
      o.count = ibm_pkg::COUNT_W'(list_len);
      return o;
   endfunction

   // spare ids never collide with index blocks in use, so the store is only
   // ever read where it was written
   function automatic logic [ID_BITS-1:0] fresh_id();
      logic [ID_BITS-1:0] v;
      do v = ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1)); while (id_taken[v]);
      return v;
   endfunction

   function automatic map_req_type make_request(phase_type ph);
      map_req_type q;
      int unsigned pick;
      int unsigned append_pct;
      int unsigned good_pct;
      int unsigned want;
      append_pct = (ph == PHASE_MIX) ? 55 : (ph == PHASE_FILL) ? 92 : 50;
      good_pct   = (ph == PHASE_FILL) ? 97 : 85;
      q.op          = ibm_pkg::OP_LOOKUP;
      q.lidx        = ibm_pkg::LIDX_W'($urandom_range(0, (1 << ibm_pkg::LIDX_W) - 1));
      q.new_block   = ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
      q.spare_first = fresh_id();
      do q.spare_second = fresh_id(); while (q.spare_second == q.spare_first);
      q.offered     = ibm_pkg::SPARES_W'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < append_pct) begin
         q.op = ibm_pkg::OP_APPEND;
         want = spares_needed();
         if (ph != PHASE_TAIL && $urandom_range(0, 99) < good_pct)
            q.offered = ibm_pkg::SPARES_W'($urandom_range(want, 3));
      end else begin
         pick = $urandom_range(0, 99);
         if (list_len != 0 && pick < 70)
            q.lidx = ibm_pkg::LIDX_W'($urandom_range(0, list_len - 1));
         else if (pick < 85)
            q.lidx = ibm_pkg::LIDX_W'(list_len + $urandom_range(0, 3));
      end
      return q;
   endfunction

   task automatic add_row(map_req_type q);
      map_row_type r;
      r.req   = q;
      r.typed = 1'b0;
      directed_rows.push_back(r);
   endtask

   task automatic add_known(map_req_type q, map_rsp_type e);
      map_row_type r;
      r.req   = q;
      r.typed = 1'b1;
      r.rsp   = e;
      directed_rows.push_back(r);
   endtask

   task automatic offer(map_req_type q);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= q.op;
      req_logical_index  <= q.lidx;
      req_new_block      <= q.new_block;
      req_spare_first    <= q.spare_first;
      req_spare_second   <= q.spare_second;
      req_spares_offered <= q.offered;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic issue(map_req_type q);
      pending_outcomes.push_back(map_outcome(q));
      offer(q);
   endtask

   initial begin
      int unsigned n;
      add_known(map_req_type'{ibm_pkg::OP_LOOKUP, 13'd0, 10'd0, 10'd0, 10'd0,
                              ibm_pkg::SPARES_NONE},
                map_rsp_type'{ibm_pkg::STATUS_RANGE, 10'd0, ibm_pkg::SPARES_NONE, 13'd0});
      add_known(map_req_type'{ibm_pkg::OP_LOOKUP, 13'd8191, 10'd1023, 10'd1023, 10'd1023,
                              ibm_pkg::SPARES_ALL},
                map_rsp_type'{ibm_pkg::STATUS_RANGE, 10'd0, ibm_pkg::SPARES_NONE, 13'd0});
      add_known(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'd1023, 10'd0, 10'd0,
                              ibm_pkg::SPARES_NONE},
                map_rsp_type'{ibm_pkg::STATUS_OK, 10'd0, ibm_pkg::SPARES_NONE, 13'd1});
      add_known(map_req_type'{ibm_pkg::OP_LOOKUP, 13'd0, 10'd0, 10'd0, 10'd0,
                              ibm_pkg::SPARES_NONE},
                map_rsp_type'{ibm_pkg::STATUS_OK, 10'd1023, ibm_pkg::SPARES_NONE, 13'd1});
      // direct slots ignore any spares offered
      add_known(map_req_type'{ibm_pkg::OP_APPEND, 13'd8191, 10'd0, 10'd1023, 10'd1023,
                              ibm_pkg::SPARES_ALL},
                map_rsp_type'{ibm_pkg::STATUS_OK, 10'd0, ibm_pkg::SPARES_NONE, 13'd2});
      add_known(map_req_type'{ibm_pkg::OP_LOOKUP, 13'd1, 10'd0, 10'd0, 10'd0,
                              ibm_pkg::SPARES_NONE},
                map_rsp_type'{ibm_pkg::STATUS_OK, 10'd0, ibm_pkg::SPARES_NONE, 13'd2});
      add_known(map_req_type'{ibm_pkg::OP_LOOKUP, 13'd2, 10'd0, 10'd0, 10'd0,
                              ibm_pkg::SPARES_NONE},
                map_rsp_type'{ibm_pkg::STATUS_RANGE, 10'd0, ibm_pkg::SPARES_NONE, 13'd2});
      add_row(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h155, 10'd0, 10'd0,
                            ibm_pkg::SPARES_NONE});
      add_row(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h2AA, 10'd0, 10'd0,
                            ibm_pkg::SPARES_ONE});
      add_row(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h001, 10'd0, 10'd0,
                            ibm_pkg::SPARES_TWO});
      add_row(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h200, 10'd0, 10'd0,
                            ibm_pkg::SPARES_NONE});
      add_row(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h0F0, 10'd0, 10'd0,
                            ibm_pkg::SPARES_NONE});
      add_row(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h30F, 10'd0, 10'd0,
                            ibm_pkg::SPARES_NONE});
      add_row(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h3FE, 10'd0, 10'd0,
                            ibm_pkg::SPARES_NONE});
      add_row(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h101, 10'd0, 10'd0,
                            ibm_pkg::SPARES_NONE});
      add_row(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h0AA, 10'd0, 10'd0,
                            ibm_pkg::SPARES_NONE});
      add_row(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h355, 10'd0, 10'd0,
                            ibm_pkg::SPARES_NONE});
      add_row(map_req_type'{ibm_pkg::OP_LOOKUP, 13'd11, 10'd0, 10'd0, 10'd0,
                            ibm_pkg::SPARES_NONE});
      add_known(map_req_type'{ibm_pkg::OP_LOOKUP, 13'd12, 10'd0, 10'd0, 10'd0,
                              ibm_pkg::SPARES_NONE},
                map_rsp_type'{ibm_pkg::STATUS_RANGE, 10'd0, ibm_pkg::SPARES_NONE, 13'd12});
      // single-indirect block must open: no spare means refusal
      add_known(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h3C3, 10'd1000, 10'd1,
                              ibm_pkg::SPARES_NONE},
                map_rsp_type'{ibm_pkg::STATUS_SPARES, 10'd0, ibm_pkg::SPARES_NONE, 13'd12});
      add_known(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h3C3, 10'd1000, 10'd1,
                              ibm_pkg::SPARES_ALL},
                map_rsp_type'{ibm_pkg::STATUS_OK, 10'd0, ibm_pkg::SPARES_ONE, 13'd13});
      add_known(map_req_type'{ibm_pkg::OP_LOOKUP, 13'd12, 10'd0, 10'd0, 10'd0,
                              ibm_pkg::SPARES_NONE},
                map_rsp_type'{ibm_pkg::STATUS_OK, 10'h3C3, ibm_pkg::SPARES_NONE, 13'd13});
      add_known(map_req_type'{ibm_pkg::OP_APPEND, 13'd0, 10'h03C, 10'd7, 10'd0,
                              ibm_pkg::SPARES_ONE},
                map_rsp_type'{ibm_pkg::STATUS_OK, 10'd0, ibm_pkg::SPARES_NONE, 13'd14});
      add_known(map_req_type'{ibm_pkg::OP_LOOKUP, 13'd13, 10'd0, 10'd0, 10'd0,
                              ibm_pkg::SPARES_NONE},
                map_rsp_type'{ibm_pkg::STATUS_OK, 10'h03C, ibm_pkg::SPARES_NONE, 13'd14});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) begin
            void'(map_outcome(directed_rows[i].req));
            pending_outcomes.push_back(directed_rows[i].rsp);
            offer(directed_rows[i].req);
         end else begin
            issue(directed_rows[i].req);
         end
      end

      for (n = 0; n < MIX_ITEMS; n++) begin
         calm = (n >= 300 && n < 450);
         if (n == 700) hold_request = 1'b1;
         if (n == 900) begin
            // drain everything before going on
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_outcomes.size() != 0);
         end
         issue(make_request(PHASE_MIX));
      end
      repeat (FILL_ITEMS) issue(make_request(PHASE_FILL));
      repeat (TAIL_ITEMS) issue(make_request(PHASE_TAIL));
      req_valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("PASS inode_block_map_unit");
      else
         $display("FAIL inode_block_map_unit");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_served) begin
         // long hold-off so the block backs up into the request side
         rsp_ready   <= 1'b0;
         hold_left   <= HOLD_CYCLES;
         hold_served <= 1'b1;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            head = pending_outcomes.pop_front();
            if (rsp_status !== head.status) begin
               $error("status: expected %0d, got %0d", head.status, rsp_status);
               mismatches++;
            end
            if (rsp_found_block !== head.found) begin
               $error("found_block: expected %0d, got %0d", head.found, rsp_found_block);
               mismatches++;
            end
            if (rsp_spares_used !== head.used) begin
               $error("spares_used: expected %0d, got %0d", head.used, rsp_spares_used);
               mismatches++;
            end
            if (rsp_entry_count !== head.count) begin
               $error("entry_count: expected %0d, got %0d", head.count, rsp_entry_count);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAIL inode_block_map_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== inode_block_map_unit.f =====
design/ibm_pkg.sv
design/ibm_ram.sv
design/ibm_queue.sv
design/ibm_front.sv
design/ibm_back.sv
design/inode_block_map_unit.sv
verif/inode_block_map_unit_test.sv
